// ----- rtl/core/box_crop_centroid_range_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the box crop centroid range block
// Short forms of the concurrent assertions used across the core, all clocked
// on clk_i and switched off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BOX_CROP_CENTROID_RANGE_MACROS_SVH
`define BOX_CROP_CENTROID_RANGE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold at every clock edge out of reset.
`define BCCR_ASSERT_ALW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

// ----- rtl/core/bccr_pkg.sv -----
// ----------------------------------------------------------------------------
// Box crop centroid range package
// Widths, reset values, register indexes and the payload types shared by the
// front end, the back end and the top level.
// ----------------------------------------------------------------------------
package bccr_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned CountW    = 18;
  localparam int unsigned SumW      = 49;
  localparam int unsigned DistW     = 31;
  localparam int unsigned SqW       = 64;
  localparam int unsigned RootW     = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned MaxPoints = 131072;

  // -1.5 m and +1.5 m in Q15.16.
  localparam logic signed [CoordW-1:0] BoundLowRst  = 32'shFFFE8000;
  localparam logic signed [CoordW-1:0] BoundHighRst = 32'sh00018000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgYLow  = 2'd0,
    CfgYHigh = 2'd1,
    CfgZLow  = 2'd2,
    CfgZHigh = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic                     last_point;
  } point_t;

  typedef struct packed {
    logic signed [CoordW-1:0] centroid_x;
    logic signed [CoordW-1:0] centroid_y;
    logic signed [CoordW-1:0] centroid_z;
    logic [DistW-1:0]         centroid_distance;
    logic [CountW-1:0]        kept_points;
    logic                     no_points_kept;
  } result_t;

  // Totals of one finished scan, handed from the front end to the back end.
  typedef struct packed {
    logic signed [SumW-1:0] x_sum;
    logic signed [SumW-1:0] y_sum;
    logic signed [SumW-1:0] z_sum;
    logic [CountW-1:0]      count;
  } scan_t;

endpackage

// ----- rtl/core/box_crop_centroid_range.sv -----
// ----------------------------------------------------------------------------
// Box crop centroid range
// Region-of-interest centroid and range of a lidar scan.
// ----------------------------------------------------------------------------
// The block takes the points of a lidar scan, one transaction per point, as
// signed Q15.16 x, y and z in metres, and keeps a point when its y and its z
// both lie within the inclusive bounds held in four configuration registers
// (y low, y high, z low, z high at indexes 0 to 3, each reset to -1.5 m or
// +1.5 m). The front end accepts one point every clock cycle while the queue
// has room, adds kept points to 49-bit running sums and counts them up to
// 131072, beyond which further kept points are ignored. With the point that
// carries the last flag, the totals of the scan go into a queue of QueueDepth
// entries and the sums are cleared, so the next scan can stream in at once.
// The back end turns each queued scan into one result transaction: the
// centroid (each sum divided by the count, truncated towards zero), the floor
// of its Euclidean distance from the origin saturated at 2^31-1, the count,
// and a flag that is set, with all other fields zero, when no point was kept.
// A scan passes through three serial 49-bit divisions at one quotient bit per
// cycle, the squares on a single 32x32 multiplier, the square root and the
// hand-over; an empty scan goes straight to the hand-over. Input is refused
// only while the queue is full, that is when scans shorter than the back-end
// time arrive faster than the divider can retire them. The result sits in an
// output register, so the back end starts on the next queued scan while the
// previous result waits to be taken. Configuration writes take effect at once
// and should be made only while the block is idle.
// ----------------------------------------------------------------------------
module box_crop_centroid_range
  import bccr_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoordW-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  point_t             in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output result_t            out_data_o
);

  // Hand-over between the front end and the scan queue.
  logic  push;
  scan_t push_data;
  logic  q_full;

  // Hand-over between the scan queue and the back end.
  logic  pop;
  scan_t pop_data;
  logic  q_empty;

  // Bound test and accumulation at the point rate.
  bccr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (q_full)
  );

  // Finished scans waiting for the divider and square root.
  bccr_fifo #(
    .Depth (QueueDepth),
    .Width ($bits(scan_t))
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty)
  );

  // One scan at a time: divide, square, root, then register the result.
  bccr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/core/bccr_fifo.sv -----
// ----------------------------------------------------------------------------
// Scan queue
// A small register queue that holds finished scan totals until the back end
// is free to work on them.
// ----------------------------------------------------------------------------
`include "box_crop_centroid_range_macros.svh"

module bccr_fifo #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `BCCR_ASSERT_IMP(a_no_overflow, push_i, !full_o, "scan queue written while full")
  `BCCR_ASSERT_IMP(a_no_underflow, pop_i, !empty_o, "scan queue read while empty")

endmodule

// ----- rtl/core/bccr_front.sv -----
// ----------------------------------------------------------------------------
// Box crop front end
// Holds the crop bounds, tests each point against them and keeps the running
// sums and count of the current scan. The totals of a scan are pushed into the
// scan queue with its last point.
// ----------------------------------------------------------------------------
`include "box_crop_centroid_range_macros.svh"

module bccr_front
  import bccr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoordW-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  point_t             in_data_i,
  output logic               push_o,
  output scan_t              push_data_o,
  input  logic               full_i
);

  logic signed [CoordW-1:0] y_lo_q, y_hi_q, z_lo_q, z_hi_q;
  logic signed [SumW-1:0]   x_sum_q, y_sum_q, z_sum_q;
  logic signed [SumW-1:0]   x_sum_d, y_sum_d, z_sum_d;
  logic [CountW-1:0]        kept_q, kept_d;
  logic                     accept;
  logic                     in_box;
  logic                     keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_lo_q <= BoundLowRst;
      y_hi_q <= BoundHighRst;
      z_lo_q <= BoundLowRst;
      z_hi_q <= BoundHighRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgYLow:  y_lo_q <= cfg_data_i;
        CfgYHigh: y_hi_q <= cfg_data_i;
        CfgZLow:  z_lo_q <= cfg_data_i;
        CfgZHigh: z_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The queue takes a scan whenever it has room, so a full queue is the only stall.
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  assign in_box = (in_data_i.point_y >= y_lo_q) && (in_data_i.point_y <= y_hi_q) &&
                  (in_data_i.point_z >= z_lo_q) && (in_data_i.point_z <= z_hi_q);
  assign keep   = in_box && (kept_q < CountW'(MaxPoints));

  always_comb begin
    x_sum_d = x_sum_q;
    y_sum_d = y_sum_q;
    z_sum_d = z_sum_q;
    kept_d  = kept_q;
    if (keep) begin
      x_sum_d = x_sum_q + {{(SumW-CoordW){in_data_i.point_x[CoordW-1]}}, in_data_i.point_x};
      y_sum_d = y_sum_q + {{(SumW-CoordW){in_data_i.point_y[CoordW-1]}}, in_data_i.point_y};
      z_sum_d = z_sum_q + {{(SumW-CoordW){in_data_i.point_z[CoordW-1]}}, in_data_i.point_z};
      kept_d  = kept_q + 1'b1;
    end
  end

  assign push_o            = accept && in_data_i.last_point;
  assign push_data_o.x_sum = x_sum_d;
  assign push_data_o.y_sum = y_sum_d;
  assign push_data_o.z_sum = z_sum_d;
  assign push_data_o.count = kept_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_sum_q <= '0;
      y_sum_q <= '0;
      z_sum_q <= '0;
      kept_q  <= '0;
    end else if (accept) begin
      if (in_data_i.last_point) begin
        x_sum_q <= '0;
        y_sum_q <= '0;
        z_sum_q <= '0;
        kept_q  <= '0;
      end else begin
        x_sum_q <= x_sum_d;
        y_sum_q <= y_sum_d;
        z_sum_q <= z_sum_d;
        kept_q  <= kept_d;
      end
    end
  end

  `BCCR_ASSERT_ALW(a_count_bound, kept_q <= CountW'(MaxPoints), "kept count above its limit")

endmodule

// ----- rtl/core/bccr_back.sv -----
// ----------------------------------------------------------------------------
// Centroid and range back end
// Takes the totals of one scan from the queue, divides each sum by the count
// one quotient bit a cycle, squares and adds the three means, takes the
// integer square root two radicand bits a cycle and registers the result.
// ----------------------------------------------------------------------------
`include "box_crop_centroid_range_macros.svh"

module bccr_back
  import bccr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    empty_i,
  output logic    pop_o,
  input  scan_t   pop_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  localparam int unsigned StepW = $clog2(SumW + 2);
  localparam int unsigned RemW  = RootW + 2;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StDiv  = 5'b00010,
    StSqr  = 5'b00100,
    StRoot = 5'b01000,
    StDone = 5'b10000
  } back_state_e;

  back_state_e state_q, state_d;
  logic [1:0]       lane_q;
  logic [StepW-1:0] step_q;
  logic             out_valid_q;
  result_t          out_data_q;

  scan_t                    scan_q;
  logic                     empty_q;
  logic signed [CoordW-1:0] cent_x_q, cent_y_q, cent_z_q;
  logic [SumW-1:0]          dvd_q, dvd_d;
  logic [CountW-1:0]        rem_q, rem_d;
  logic                     neg_q;
  logic [SqW-1:0]           prod_q, acc_q, rad_q;
  logic [RemW-1:0]          srem_q, srem_d;
  logic [RootW-1:0]         root_q, root_d;

  logic                     div_last;
  logic                     load_out;
  logic signed [SumW-1:0]   div_src;
  logic [SumW-1:0]          div_mag;
  logic [CountW:0]          rem_sh, rem_sub;
  logic                     div_ge;
  logic [CoordW:0]          q_mag, q_signed;
  logic signed [CoordW-1:0] sq_op;
  logic signed [SqW-1:0]    sq_prod;
  logic [RemW+1:0]          rs_sh, rs_trial, rs_sub;
  logic                     root_ge;
  result_t                  res;

  assign pop_o    = (state_q == StIdle) && !empty_i;
  assign div_last = (step_q == StepW'(SumW + 1));
  assign load_out = (state_q == StDone) && (!out_valid_q || out_ready_i);

  // Restoring division of the sum magnitude by the count.
  always_comb begin
    case (lane_q)
      2'd0:    div_src = scan_q.x_sum;
      2'd1:    div_src = scan_q.y_sum;
      2'd2:    div_src = scan_q.z_sum;
      default: div_src = '0;
    endcase
  end

  assign div_mag  = div_src[SumW-1] ? (~div_src + 1'b1) : div_src;
  assign rem_sh   = {rem_q, dvd_q[SumW-1]};
  assign div_ge   = (rem_sh >= {1'b0, scan_q.count});
  assign rem_sub  = rem_sh - {1'b0, scan_q.count};
  assign rem_d    = div_ge ? rem_sub[CountW-1:0] : rem_sh[CountW-1:0];
  assign dvd_d    = {dvd_q[SumW-2:0], div_ge};
  // The mean lies in the coordinate range, so 33 quotient bits are enough.
  assign q_mag    = dvd_q[CoordW:0];
  assign q_signed = neg_q ? (~q_mag + 1'b1) : q_mag;

  always_comb begin
    case (step_q[1:0])
      2'd0:    sq_op = cent_x_q;
      2'd1:    sq_op = cent_y_q;
      2'd2:    sq_op = cent_z_q;
      default: sq_op = '0;
    endcase
  end

  assign sq_prod = sq_op * sq_op;

  // Digit-by-digit square root, two radicand bits a step.
  assign rs_sh    = {srem_q, rad_q[SqW-1 -: 2]};
  assign rs_trial = {2'b00, root_q, 2'b01};
  assign root_ge  = (rs_sh >= rs_trial);
  assign rs_sub   = rs_sh - rs_trial;
  assign srem_d   = root_ge ? rs_sub[RemW-1:0] : rs_sh[RemW-1:0];
  assign root_d   = {root_q[RootW-2:0], root_ge};

  always_comb begin
    if (empty_q) begin
      res                = '0;
      res.no_points_kept = 1'b1;
    end else begin
      res.centroid_x        = cent_x_q;
      res.centroid_y        = cent_y_q;
      res.centroid_z        = cent_z_q;
      res.centroid_distance = root_q[RootW-1] ? '1 : root_q[DistW-1:0];
      res.kept_points       = scan_q.count;
      res.no_points_kept    = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (!empty_i) begin
          state_d = (pop_data_i.count == '0) ? StDone : StDiv;
        end
      end
      StDiv: begin
        if (div_last && (lane_q == 2'd2)) begin
          state_d = StSqr;
        end
      end
      StSqr: begin
        if (step_q == StepW'(3)) begin
          state_d = StRoot;
        end
      end
      StRoot: begin
        if (step_q == StepW'(RootW - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      lane_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StDiv: begin
          if (div_last) begin
            step_q <= '0;
            lane_q <= lane_q + 1'b1;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        StSqr: begin
          step_q <= (step_q == StepW'(3)) ? '0 : step_q + 1'b1;
        end
        StRoot: begin
          step_q <= step_q + 1'b1;
        end
        default: begin
          step_q <= '0;
          lane_q <= '0;
        end
      endcase
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (pop_o) begin
          scan_q  <= pop_data_i;
          empty_q <= (pop_data_i.count == '0);
        end
      end
      StDiv: begin
        if (step_q == '0) begin
          dvd_q <= div_mag;
          rem_q <= '0;
          neg_q <= div_src[SumW-1];
        end else if (!div_last) begin
          dvd_q <= dvd_d;
          rem_q <= rem_d;
        end else begin
          case (lane_q)
            2'd0:    cent_x_q <= q_signed[CoordW-1:0];
            2'd1:    cent_y_q <= q_signed[CoordW-1:0];
            default: cent_z_q <= q_signed[CoordW-1:0];
          endcase
        end
      end
      StSqr: begin
        prod_q <= sq_prod;
        acc_q  <= (step_q == '0) ? '0 : acc_q + prod_q;
        if (step_q == StepW'(3)) begin
          rad_q  <= acc_q + prod_q;
          srem_q <= '0;
          root_q <= '0;
        end
      end
      StRoot: begin
        rad_q  <= rad_q << 2;
        srem_q <= srem_d;
        root_q <= root_d;
      end
      StDone: begin
        if (load_out) begin
          out_data_q <= res;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `BCCR_ASSERT_IMP(a_div_nonzero, state_q == StDiv, scan_q.count != '0,
                   "division started with a zero count")
  `BCCR_ASSERT_IMP(a_empty_zero, out_valid_o && out_data_o.no_points_kept,
                   out_data_o.kept_points == '0 && out_data_o.centroid_distance == '0,
                   "empty scan result carries non-zero fields")
  `BCCR_ASSERT_IMP(a_pop_idle, pop_o, state_q == StIdle && !out_valid_o || state_q == StIdle,
                   "scan taken from the queue while busy")

endmodule
